@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/asis_pkg.sv @@
// Shared constants, register indexes and types for the sprite inverse scanner.
package asis_pkg;

    localparam int MAX_SPRITE_SIDE = 256;
    localparam int MAX_BOX_SIDE    = 512;

    // fixed field widths
    localparam int STEP_W   = 16;   // Q4.12 matrix entries
    localparam int START_W  = 24;   // Q12.12 start position
    localparam int ACC_W    = 32;   // DDA accumulators
    localparam int FRAC_W   = 12;
    localparam int ORG_W    = 10;   // box corner
    localparam int SCR_W    = 11;   // screen coordinates
    localparam int IDX_W    = 16;   // texel index
    localparam int CFG_BOX_W = 10;
    localparam int CFG_SPR_W = 9;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // derived from the size limits and field widths
    localparam int BOX_W   = $clog2(MAX_BOX_SIDE + 1);
    localparam int COUNT_W = $clog2(MAX_BOX_SIDE);
    localparam int SPR_W   = $clog2(MAX_SPRITE_SIDE + 1);
    localparam int SPR_C_W = $clog2(MAX_SPRITE_SIDE);
    localparam int RMAG_W  = ACC_W + 1 - FRAC_W;

    // stream layout
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    // operation codes
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_START = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INV_ROW0_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_ROW0_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_ROW1_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_ROW1_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd7;

    typedef struct packed {
        logic [STEP_W-1:0] du_col;
        logic [STEP_W-1:0] dv_col;
        logic [STEP_W-1:0] du_row;
        logic [STEP_W-1:0] dv_row;
        logic [BOX_W-1:0]  bw;
        logic [BOX_W-1:0]  bh;
    } dda_cfg_t;

    typedef struct packed {
        logic                in_box;
        logic                last;
        logic [SCR_W-1:0]    sx;
        logic [SCR_W-1:0]    sy;
        logic [ACC_W-1:0]    u;
        logic [ACC_W-1:0]    v;
    } pix_t;

    typedef struct packed {
        logic                in_box;
        logic                hit;
        logic                last;
        logic [SCR_W-1:0]    sx;
        logic [SCR_W-1:0]    sy;
        logic [IDX_W-1:0]    index;
    } res_t;

endpackage

@@ rtl/core/affine_sprite_inverse_scanner.sv @@
// Top level of the affine sprite inverse scanner.
//
//  channel   direction  group            request carries
//  s_axis    in         tvalid/tready    step or start (tuser), start position and corner
//  m_axis    out        tvalid/tready    one screen pixel result per request, tlast at box end
//  cfg       in         we/index/data    inverse matrix, box and sprite sizes
//
// One request per clock while the output is not stalled, one result per request.
// The DDA walker output is registered into the pixel snapshot; the texel stage
// (rounding, bound check, one 8x9 multiply) then loads the output register.
// Reset clears the walker, both valid flags and the registers to their defaults.
// A held m_axis stalls the output register; s_axis stays ready while the
// snapshot stage is empty or can move on.
module affine_sprite_inverse_scanner
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // start_u[23:0], start_v[47:24], box_x[57:48], box_y[67:58], zero pad
    input  logic [asis_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // operation
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // screen_x[10:0], screen_y[21:11], texel_index[37:22], zero pad
    output logic [asis_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // in_box[0], texel_hit[1]
    output logic [asis_pkg::M_TUSER_W-1:0]       m_axis_tuser,
    output logic                                 m_axis_tlast,
    input  logic                                 cfg_we,
    input  logic [asis_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [asis_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import asis_pkg::*;

    logic [STEP_W-1:0]    r0x_reg, r0y_reg, r1x_reg, r1y_reg;
    logic [CFG_BOX_W-1:0] bw_cfg_reg, bh_cfg_reg;
    logic [CFG_SPR_W-1:0] sw_cfg_reg, sh_cfg_reg;

    dda_cfg_t         dda_cfg;
    logic [SPR_W-1:0] sw_sat, sh_sat;
    pix_t             pix;
    res_t             res;

    logic  s1_valid_reg;
    pix_t  s1_pix_reg;
    logic  m_valid_reg;
    res_t  m_res_reg;

    logic  advance;
    logic  accept;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r0x_reg    <= STEP_W'(4096);
            r0y_reg    <= '0;
            r1x_reg    <= '0;
            r1y_reg    <= STEP_W'(4096);
            bw_cfg_reg <= '0;
            bh_cfg_reg <= '0;
            sw_cfg_reg <= CFG_SPR_W'(1);
            sh_cfg_reg <= CFG_SPR_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INV_ROW0_X:    r0x_reg    <= cfg_data;
                REG_INV_ROW0_Y:    r0y_reg    <= cfg_data;
                REG_INV_ROW1_X:    r1x_reg    <= cfg_data;
                REG_INV_ROW1_Y:    r1y_reg    <= cfg_data;
                REG_BOX_WIDTH:     bw_cfg_reg <= cfg_data[CFG_BOX_W-1:0];
                REG_BOX_HEIGHT:    bh_cfg_reg <= cfg_data[CFG_BOX_W-1:0];
                REG_SPRITE_WIDTH:  sw_cfg_reg <= cfg_data[CFG_SPR_W-1:0];
                REG_SPRITE_HEIGHT: sh_cfg_reg <= cfg_data[CFG_SPR_W-1:0];
                default:           r0x_reg    <= r0x_reg;
            endcase
        end
    end

    // size clamps
    always_comb
    begin
        dda_cfg.du_col = r0x_reg;
        dda_cfg.dv_col = r0y_reg;
        dda_cfg.du_row = r1x_reg;
        dda_cfg.dv_row = r1y_reg;
        dda_cfg.bw = (int'(bw_cfg_reg) > MAX_BOX_SIDE) ? BOX_W'(MAX_BOX_SIDE) : BOX_W'(bw_cfg_reg);
        dda_cfg.bh = (int'(bh_cfg_reg) > MAX_BOX_SIDE) ? BOX_W'(MAX_BOX_SIDE) : BOX_W'(bh_cfg_reg);
        sw_sat = (int'(sw_cfg_reg) > MAX_SPRITE_SIDE) ? SPR_W'(MAX_SPRITE_SIDE)
                                                      : SPR_W'(sw_cfg_reg);
        sh_sat = (int'(sh_cfg_reg) > MAX_SPRITE_SIDE) ? SPR_W'(MAX_SPRITE_SIDE)
                                                      : SPR_W'(sh_cfg_reg);
    end

    assign advance       = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    asis_dda u_dda
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .op      (s_axis_tuser),
        .start_u (s_axis_tdata[23:0]),
        .start_v (s_axis_tdata[47:24]),
        .box_x   (s_axis_tdata[57:48]),
        .box_y   (s_axis_tdata[67:58]),
        .cfg     (dda_cfg),
        .pix     (pix)
    );

    asis_texel u_texel
    (
        .pix (s1_pix_reg),
        .sw  (sw_sat),
        .sh  (sh_sat),
        .res (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready)
        begin
            s1_pix_reg <= pix;
        end
        if (advance)
        begin
            m_res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - 2*SCR_W - IDX_W)'(0),
                            m_res_reg.index, m_res_reg.sy, m_res_reg.sx};
    assign m_axis_tuser  = {m_res_reg.hit, m_res_reg.in_box};
    assign m_axis_tlast  = m_res_reg.last;

endmodule

@@ rtl/core/asis_dda.sv @@
// Raster walker: box counters and the sprite-space DDA accumulators.
module asis_dda
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic                              op,
    input  logic [asis_pkg::START_W-1:0]      start_u,
    input  logic [asis_pkg::START_W-1:0]      start_v,
    input  logic [asis_pkg::ORG_W-1:0]        box_x,
    input  logic [asis_pkg::ORG_W-1:0]        box_y,
    input  asis_pkg::dda_cfg_t                cfg,
    output asis_pkg::pix_t                    pix
);
    import asis_pkg::*;

    logic               active_reg, active_next;
    logic [COUNT_W-1:0] col_reg, col_next;
    logic [COUNT_W-1:0] row_reg, row_next;
    logic [ORG_W-1:0]   org_x_reg, org_x_next;
    logic [ORG_W-1:0]   org_y_reg, org_y_next;
    logic [ACC_W-1:0]   u_reg, u_next;
    logic [ACC_W-1:0]   v_reg, v_next;
    logic [ACC_W-1:0]   rsu_reg, rsu_next;
    logic [ACC_W-1:0]   rsv_reg, rsv_next;

    logic               pixel;
    logic [BOX_W-1:0]   col_inc;
    logic [BOX_W-1:0]   row_inc;
    logic               col_wrap;
    logic [ACC_W-1:0]   rsu_step;
    logic [ACC_W-1:0]   rsv_step;
    logic [ACC_W-1:0]   su_ext;
    logic [ACC_W-1:0]   sv_ext;

    always_comb
    begin
        pixel    = active_reg && (BOX_W'(col_reg) < cfg.bw) && (BOX_W'(row_reg) < cfg.bh);
        col_inc  = BOX_W'(col_reg) + BOX_W'(1);
        row_inc  = BOX_W'(row_reg) + BOX_W'(1);
        col_wrap = (col_inc == cfg.bw);
        rsu_step = rsu_reg + {{(ACC_W-STEP_W){cfg.du_row[STEP_W-1]}}, cfg.du_row};
        rsv_step = rsv_reg + {{(ACC_W-STEP_W){cfg.dv_row[STEP_W-1]}}, cfg.dv_row};
        su_ext   = {{(ACC_W-START_W){start_u[START_W-1]}}, start_u};
        sv_ext   = {{(ACC_W-START_W){start_v[START_W-1]}}, start_v};

        // a start request never yields a box pixel
        pix.in_box = pixel && (op == OP_STEP);
        pix.last   = pixel && (op == OP_STEP) && col_wrap && (row_inc == cfg.bh);
        pix.sx     = SCR_W'({org_x_reg[ORG_W-1], org_x_reg}) + SCR_W'(col_reg);
        pix.sy     = SCR_W'({org_y_reg[ORG_W-1], org_y_reg}) + SCR_W'(row_reg);
        pix.u      = u_reg;
        pix.v      = v_reg;

        active_next = active_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        org_x_next  = org_x_reg;
        org_y_next  = org_y_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        rsu_next    = rsu_reg;
        rsv_next    = rsv_reg;

        if (accept)
        begin
            if (op == OP_START)
            begin
                active_next = (cfg.bw != '0) && (cfg.bh != '0);
                col_next    = '0;
                row_next    = '0;
                org_x_next  = box_x;
                org_y_next  = box_y;
                u_next      = su_ext;
                v_next      = sv_ext;
                rsu_next    = su_ext;
                rsv_next    = sv_ext;
            end
            else if (!pixel)
            begin
                active_next = 1'b0;
            end
            else if (col_wrap)
            begin
                // end of row: restart from the next row's left edge
                col_next = '0;
                row_next = COUNT_W'(row_inc);
                rsu_next = rsu_step;
                rsv_next = rsv_step;
                u_next   = rsu_step;
                v_next   = rsv_step;
                if (row_inc == cfg.bh)
                begin
                    active_next = 1'b0;
                end
            end
            else
            begin
                col_next = COUNT_W'(col_inc);
                u_next   = u_reg + {{(ACC_W-STEP_W){cfg.du_col[STEP_W-1]}}, cfg.du_col};
                v_next   = v_reg + {{(ACC_W-STEP_W){cfg.dv_col[STEP_W-1]}}, cfg.dv_col};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
            org_x_reg  <= '0;
            org_y_reg  <= '0;
            u_reg      <= '0;
            v_reg      <= '0;
            rsu_reg    <= '0;
            rsv_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            org_x_reg  <= org_x_next;
            org_y_reg  <= org_y_next;
            u_reg      <= u_next;
            v_reg      <= v_next;
            rsu_reg    <= rsu_next;
            rsv_reg    <= rsv_next;
        end
    end

endmodule

@@ rtl/core/asis_texel.sv @@
// Texel lookup: rounds the sprite position, checks bounds, forms the index.
module asis_texel
(
    input  asis_pkg::pix_t                 pix,
    input  logic [asis_pkg::SPR_W-1:0]     sw,
    input  logic [asis_pkg::SPR_W-1:0]     sh,
    output asis_pkg::res_t                 res
);
    import asis_pkg::*;

    logic                     u_neg, v_neg;
    logic [ACC_W-1:0]         u_mag, v_mag;
    logic [ACC_W:0]           u_sum, v_sum;
    logic [RMAG_W-1:0]        ru, rv;
    logic                     hit;
    logic [SPR_C_W+SPR_W-1:0] row_off;
    logic [SPR_C_W+SPR_W:0]   idx_sum;

    // round half away from zero on the magnitude
    always_comb
    begin
        u_neg   = pix.u[ACC_W-1];
        v_neg   = pix.v[ACC_W-1];
        u_mag   = u_neg ? (~pix.u + ACC_W'(1)) : pix.u;
        v_mag   = v_neg ? (~pix.v + ACC_W'(1)) : pix.v;
        u_sum   = {1'b0, u_mag} + (ACC_W+1)'(1 << (FRAC_W - 1));
        v_sum   = {1'b0, v_mag} + (ACC_W+1)'(1 << (FRAC_W - 1));
        ru      = u_sum[ACC_W:FRAC_W];
        rv      = v_sum[ACC_W:FRAC_W];
        // a negative value that rounds to zero still counts as zero
        hit     = !(u_neg && ru != '0) && !(v_neg && rv != '0)
                  && (ru < RMAG_W'(sw)) && (rv < RMAG_W'(sh));
        row_off = (SPR_C_W+SPR_W)'(rv[SPR_C_W-1:0]) * (SPR_C_W+SPR_W)'(sw);
        idx_sum = (SPR_C_W+SPR_W+1)'(row_off) + (SPR_C_W+SPR_W+1)'(ru[SPR_C_W-1:0]);

        res.in_box = pix.in_box;
        res.hit    = pix.in_box && hit;
        res.last   = pix.in_box && pix.last;
        res.sx     = pix.in_box ? pix.sx : '0;
        res.sy     = pix.in_box ? pix.sy : '0;
        res.index  = (pix.in_box && hit) ? IDX_W'(idx_sum) : '0;
    end

endmodule

@@ rtl/core/asis_checker.sv @@
// Port-level checks for the sprite inverse scanner, bound to the top level.
`include "assert_macros.svh"

module asis_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [asis_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    input  logic [asis_pkg::M_TUSER_W-1:0]       m_axis_tuser,
    input  logic                                 m_axis_tlast
);
    import asis_pkg::*;

    localparam int IDX_LSB = 2 * SCR_W;

    // a stalled result holds
    `ASSERT_CLK(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

    // box end and texel hit only on box pixels
    `ASSERT_CLK(a_last_in_box, clk, rst_n, m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0], "tlast without a box pixel")
    `ASSERT_CLK(a_hit_in_box, clk, rst_n, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0], "texel hit without a box pixel")

    // a miss or a non-pixel result carries a zero index
    `ASSERT_CLK(a_miss_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[IDX_LSB+IDX_W-1:IDX_LSB] == '0, "miss with nonzero texel index")

    // no result leaves once reset has been seen at an edge
    `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !m_axis_tvalid, "result valid during reset")

endmodule

bind affine_sprite_inverse_scanner asis_checker u_asis_checker (.*);

@@ test/tb_top.sv @@
// Self-checking testbench for the affine sprite inverse scanner.
module tb_top;
    import asis_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        logic        in_box;
        logic        hit;
        logic [10:0] sx;
        logic [10:0] sy;
        logic [15:0] index;
        logic        last;
    } pixel_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [M_TUSER_W-1:0]  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    affine_sprite_inverse_scanner dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    int send_idle_pct = 27;
    int stall_pct = 55;
    int fail_count = 0;
    int idle_cycles = 0;
    // newest at the front, oldest at the back
    pixel_t expected_pixels[$];

    // shadow registers and scan state of the block
    logic [15:0]       m_du_col = 16'h1000;
    logic [15:0]       m_dv_col = 16'h0000;
    logic [15:0]       m_du_row = 16'h0000;
    logic [15:0]       m_dv_row = 16'h1000;
    logic [9:0]        m_box_w = 10'd0;
    logic [9:0]        m_box_h = 10'd0;
    logic [8:0]        m_spr_w = 9'd1;
    logic [8:0]        m_spr_h = 9'd1;
    logic              walking = 1'b0;
    int                col_cnt = 0;
    int                row_cnt = 0;
    logic signed [9:0] corner_x = '0;
    logic signed [9:0] corner_y = '0;
    logic [31:0]       u_acc = '0;
    logic [31:0]       v_acc = '0;
    logic [31:0]       row_u = '0;
    logic [31:0]       row_v = '0;

    function automatic int clamp_side(input int v, input int lim);
        return (v > lim) ? lim : v;
    endfunction

    // Q20.12 accumulator to nearest texel, halves away from zero
    function automatic longint round_to_texel(input logic [31:0] acc);
        longint s;
        s = longint'($signed(acc));
        if (s >= 0)
            return (s + 2048) >>> 12;
        return -((2048 - s) >>> 12);
    endfunction

    task automatic scan_pixel(input logic op, input logic [S_TDATA_W-1:0] req,
                              output pixel_t px);
        int     bw;
        int     bh;
        int     tx;
        int     ty;
        longint sw;
        longint sh;
        longint ru;
        longint rv;
        longint flat;
        bw = clamp_side(int'(m_box_w), MAX_BOX_SIDE);
        bh = clamp_side(int'(m_box_h), MAX_BOX_SIDE);
        sw = longint'(clamp_side(int'(m_spr_w), MAX_SPRITE_SIDE));
        sh = longint'(clamp_side(int'(m_spr_h), MAX_SPRITE_SIDE));
        px = '0;
        if (op == OP_START)
        begin
            u_acc = {{8{req[23]}}, req[23:0]};
            v_acc = {{8{req[47]}}, req[47:24]};
            row_u = u_acc;
            row_v = v_acc;
            corner_x = req[57:48];
            corner_y = req[67:58];
            col_cnt = 0;
            row_cnt = 0;
            walking = (bw != 0) && (bh != 0);
        end
        else if (!walking || col_cnt >= bw || row_cnt >= bh)
        begin
            walking = 1'b0;
        end
        else
        begin
            ru = round_to_texel(u_acc);
            rv = round_to_texel(v_acc);
            tx = int'(corner_x) + col_cnt;
            ty = int'(corner_y) + row_cnt;
            flat = ru + rv * sw;
            px.in_box = 1'b1;
            px.hit = (ru >= 0) && (rv >= 0) && (ru < sw) && (rv < sh);
            px.sx = tx[10:0];
            px.sy = ty[10:0];
            px.index = px.hit ? flat[15:0] : 16'd0;
            px.last = (col_cnt + 1 == bw) && (row_cnt + 1 == bh);

            col_cnt++;
            u_acc = u_acc + {{16{m_du_col[15]}}, m_du_col};
            v_acc = v_acc + {{16{m_dv_col[15]}}, m_dv_col};
            if (col_cnt >= bw)
            begin
                col_cnt = 0;
                row_cnt++;
                row_u = row_u + {{16{m_du_row[15]}}, m_du_row};
                row_v = row_v + {{16{m_dv_row[15]}}, m_dv_row};
                u_acc = row_u;
                v_acc = row_v;
                if (row_cnt >= bh)
                    walking = 1'b0;
            end
        end
    endtask

    // entered and left just after a falling edge; tvalid stays up on return
    task automatic send_request(input logic op, input logic [S_TDATA_W-1:0] req);
        pixel_t px;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= req;
        do
            @(posedge clk);
        while (!s_axis_tready);
        scan_pixel(op, req, px);
        expected_pixels.push_front(px);
        @(negedge clk);
    endtask

    task automatic start_box(input logic [23:0] u, input logic [23:0] v,
                             input logic [9:0] x, input logic [9:0] y);
        send_request(OP_START, {4'd0, y, x, v, u});
    endtask

    // data bits are don't-care on a step, so fill them with noise
    task automatic step_pixels(input int n);
        repeat (n)
            send_request(OP_STEP, {4'd0, 4'($urandom), $urandom, $urandom});
    endtask

    task automatic wait_for_quiet();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // leaves cfg_we high; the caller drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            REG_INV_ROW0_X:    m_du_col = value;
            REG_INV_ROW0_Y:    m_dv_col = value;
            REG_INV_ROW1_X:    m_du_row = value;
            REG_INV_ROW1_Y:    m_dv_row = value;
            REG_BOX_WIDTH:     m_box_w = value[9:0];
            REG_BOX_HEIGHT:    m_box_h = value[9:0];
            REG_SPRITE_WIDTH:  m_spr_w = value[8:0];
            REG_SPRITE_HEIGHT: m_spr_h = value[8:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic load_config(input logic [15:0] du_col, input logic [15:0] dv_col,
                               input logic [15:0] du_row, input logic [15:0] dv_row,
                               input logic [15:0] box_w, input logic [15:0] box_h,
                               input logic [15:0] spr_w, input logic [15:0] spr_h);
        wait_for_quiet();
        write_reg(REG_INV_ROW0_X, du_col);
        write_reg(REG_INV_ROW0_Y, dv_col);
        write_reg(REG_INV_ROW1_X, du_row);
        write_reg(REG_INV_ROW1_Y, dv_row);
        write_reg(REG_BOX_WIDTH, box_w);
        write_reg(REG_BOX_HEIGHT, box_h);
        write_reg(REG_SPRITE_WIDTH, spr_w);
        write_reg(REG_SPRITE_HEIGHT, spr_h);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_step();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($urandom);
            default: return 16'(int'($urandom_range(16384)) - 8192);
        endcase
    endfunction

    // bits above the register width are noise
    function automatic logic [15:0] pick_box_side();
        logic [15:0] r;
        r = 16'($urandom);
        case ($urandom_range(11))
            0: r[9:0] = 10'd0;
            1: r[9:0] = 10'($urandom_range(24, 1));
            default: r[9:0] = 10'($urandom_range(8, 1));
        endcase
        return r;
    endfunction

    function automatic logic [15:0] pick_sprite_side();
        logic [15:0] r;
        r = 16'($urandom);
        case ($urandom_range(15))
            0: r[8:0] = 9'd0;
            1: r[8:0] = 9'd511;
            2: r[8:0] = 9'd256;
            3: r[8:0] = 9'd1;
            default: r[8:0] = 9'($urandom_range(16, 1));
        endcase
        return r;
    endfunction

    // idle steps before any box, then the reset matrix with only the sizes written
    task automatic test_reset_defaults();
        step_pixels(1);
        start_box(24'h000000, 24'h000000, 10'd0, 10'd0);
        step_pixels(1);
        wait_for_quiet();
        write_reg(REG_BOX_WIDTH, 16'd3);
        write_reg(REG_BOX_HEIGHT, 16'd2);
        write_reg(REG_SPRITE_WIDTH, 16'd4);
        write_reg(REG_SPRITE_HEIGHT, 16'd4);
        cfg_we <= 1'b0;
        // u = +0.5, v = -0.5: both round away from zero
        start_box(24'h000800, 24'hFFF800, 10'h200, 10'h1FF);
        step_pixels(7);
    endtask

    // half-texel column step walks u across both sprite edges
    task automatic test_sub_texel_rounding();
        load_config(16'h0800, 16'h0000, 16'h0000, 16'h0000,
                    16'd7, 16'd1, 16'd2, 16'd1);
        start_box(24'hFFE800, 24'h0007FF, 10'd0, 10'd0);
        step_pixels(8);
    endtask

    // zero sprite width never hits; a second start drops the box in flight
    task automatic test_restart_zero_sprite();
        load_config(16'h7FFF, 16'h8000, 16'h1000, 16'hF000,
                    16'd3, 16'd2, 16'd0, 16'd256);
        start_box(24'h7FFFFF, 24'h800000, 10'h155, 10'h2AA);
        step_pixels(3);
        start_box(24'h000000, 24'h000000, 10'h3FF, 10'h001);
        step_pixels(6);
    endtask

    // box and sprite sides above the maximum saturate
    task automatic test_oversized_box();
        load_config(16'h1000, 16'h0000, 16'h8000, 16'h7FFF,
                    16'd1023, 16'd1, 16'd511, 16'd1);
        start_box(24'h000000, 24'h000000, 10'h1FF, 10'h000);
        step_pixels(513);
        load_config(16'h8000, 16'h7FFF, 16'h0000, 16'h1000,
                    16'd1, 16'd700, 16'd256, 16'd511);
        start_box(24'h000000, 24'h000000, 10'h1FF, 10'h200);
        step_pixels(513);
    endtask

    task automatic test_random_scan(input int budget, input int idle_pct, input int stall);
        int          sent;
        int          pix;
        int          sw_eff;
        int          sh_eff;
        int          coord;
        logic [23:0] u;
        logic [23:0] v;
        sent = 0;
        send_idle_pct = idle_pct;
        stall_pct = stall;
        while (sent < budget)
        begin
            if (!walking && $urandom_range(3) == 0)
                load_config(pick_step(), pick_step(), pick_step(), pick_step(),
                            pick_box_side(), pick_box_side(),
                            pick_sprite_side(), pick_sprite_side());
            if ($urandom_range(9) == 0)
            begin
                pix = 1 + int'($urandom_range(2));
                step_pixels(pix);
                sent += pix;
            end
            // mostly start near the sprite so hits and edges both show up
            sw_eff = clamp_side(int'(m_spr_w), MAX_SPRITE_SIDE);
            sh_eff = clamp_side(int'(m_spr_h), MAX_SPRITE_SIDE);
            coord = (int'($urandom_range(sw_eff + 4)) - 2) * 4096 + int'($urandom_range(4095));
            u = ($urandom_range(5) == 0) ? 24'($urandom) : 24'(coord);
            coord = (int'($urandom_range(sh_eff + 4)) - 2) * 4096 + int'($urandom_range(4095));
            v = ($urandom_range(5) == 0) ? 24'($urandom) : 24'(coord);
            start_box(u, v, 10'($urandom), 10'($urandom));
            pix = clamp_side(int'(m_box_w), MAX_BOX_SIDE) * clamp_side(int'(m_box_h), MAX_BOX_SIDE);
            if ($urandom_range(7) == 0)
                pix = int'($urandom_range(pix));
            else
                pix += int'($urandom_range(2));
            step_pixels(pix);
            sent += 1 + pix;
        end
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        pixel_t got;
        pixel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.in_box = m_axis_tuser[0];
            got.hit = m_axis_tuser[1];
            got.sx = m_axis_tdata[10:0];
            got.sy = m_axis_tdata[21:11];
            got.index = m_axis_tdata[37:22];
            got.last = m_axis_tlast;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel, expected none, got 0x%0h", $time, got);
                fail_count++;
            end
            else
            begin
                want = expected_pixels.pop_back();
                check_field("in_box", int'(want.in_box), int'(got.in_box));
                check_field("texel_hit", int'(want.hit), int'(got.hit));
                check_field("screen_x", int'(want.sx), int'(got.sx));
                check_field("screen_y", int'(want.sy), int'(got.sy));
                check_field("texel_index", int'(want.index), int'(got.index));
                check_field("last", int'(want.last), int'(got.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: watchdog, no request moved for %0d cycles", $time, idle_cycles);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_sub_texel_rounding();
        test_restart_zero_sprite();
        test_random_scan(170, 27, 55);
        test_oversized_box();
        test_random_scan(170, 55, 27);
        test_random_scan(170, 0, 0);
        wait_for_quiet();

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
